FILE: rtl/swr_pkg.sv
// Package with the types, widths and codes shared by the sliding-window receiver.
`timescale 1ns / 1ps
package swr_pkg;

  localparam int SEQ_W      = 32;
  localparam int LEN_W      = 16;
  localparam int HANDLE_W   = 16;
  localparam int MODE_W     = 2;
  localparam int WIN_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;
  localparam int SLOT_W     = SEQ_W + LEN_W + HANDLE_W;

  localparam int BUFFER_DEPTH_DEF = 64;
  localparam int WINDOW_MAX_DEF   = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(8);

  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DATA  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

  localparam logic KIND_DELIVER = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  localparam logic ACK_CUMULATIVE = 1'b0;
  localparam logic ACK_SELECTIVE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_POLICY  = 1'd1;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [SEQ_W-1:0]    seq;
    logic [LEN_W-1:0]    length;
    logic [HANDLE_W-1:0] payload_handle;
    logic                checksum_ok;
  } swr_in_t;

  typedef struct packed {
    logic                kind;
    logic [SEQ_W-1:0]    seq_res;
    logic [LEN_W-1:0]    length_res;
    logic [HANDLE_W-1:0] payload_handle_res;
    logic                last;
  } swr_out_t;

  typedef struct packed {
    logic [SEQ_W-1:0] diff;
    logic             is_zero;
    logic             is_neg;
  } swr_alu_res_t;

endpackage

FILE: rtl/sliding_window_receiver_core.sv
// Top level of the sliding-window receiver: sequencer, slot store and result staging.
// A result is staged in a pending register, then moved to the output register. A packet
// is taken only in idle, then decoded and finished; an ignored one returns from decode,
// and a cumulative ack adds an ack step. Each delivered slot adds a read then a compare
// in the shared unit; a failed compare or the window bound ends the run.
// Reset clears the slot valid bits at once; there is no clearing pass.
`timescale 1ns / 1ps
module sliding_window_receiver_core
  import swr_pkg::*;
#(
  parameter int BUFFER_DEPTH = BUFFER_DEPTH_DEF,
  parameter int WINDOW_MAX   = WINDOW_MAX_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  swr_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output swr_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int IdxW      = $clog2(BUFFER_DEPTH);
  localparam int WinCapInt = (WINDOW_MAX < BUFFER_DEPTH - 1) ? WINDOW_MAX : BUFFER_DEPTH - 1;
  localparam logic [WIN_W-1:0] WinCap = WIN_W'(WinCapInt);
  localparam logic [IdxW:0]    DepthW = (IdxW + 1)'(BUFFER_DEPTH);
  localparam logic [IdxW-1:0]  LastIdx = IdxW'(BUFFER_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_DRAIN_RD,
    S_DRAIN_CMP,
    S_ACK_EXP,
    S_FINISH
  } state_e;

  state_e                  state_q, state_d;
  swr_in_t                 in_q, in_d;
  logic [SEQ_W-1:0]        expected_q, expected_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic                    open_q, open_d;
  logic [BUFFER_DEPTH-1:0] valid_q, valid_d;
  logic [WIN_W-1:0]        window_q, window_d;
  logic                    policy_q, policy_d;
  logic [WIN_W-1:0]        w_q, w_d;
  logic [WIN_W-1:0]        cnt_q, cnt_d;
  logic                    rd_valid_q, rd_valid_d;
  swr_out_t                pend_q, pend_d;
  logic                    pend_valid_q, pend_valid_d;
  swr_out_t                out_q, out_d;
  logic                    out_valid_q, out_valid_d;

  logic                    ram_we;
  logic                    ram_re;
  logic [IdxW-1:0]         slot_idx;
  logic [IdxW:0]           slot_sum;
  logic [SLOT_W-1:0]       ram_rdata;
  logic [SEQ_W-1:0]        slot_seq;
  logic [SEQ_W-1:0]        alu_a;
  swr_alu_res_t            alu_res;
  logic [WIN_W-1:0]        w_eff;
  logic                    in_win;
  logic                    push_ok;
  logic                    emit_en;
  logic                    finish_en;
  swr_out_t                emit_item;
  logic                    drain_done_cum;

  assign slot_seq = rd_valid_q ? ram_rdata[SLOT_W-1 -: SEQ_W] : '0;
  assign alu_a    = (state_q == S_DECODE) ? in_q.seq : slot_seq;

  swr_alu u_alu (
    .a_i   (alu_a),
    .b_i   (expected_q),
    .res_o (alu_res)
  );

  assign w_eff = (window_q == '0) ? WIN_W'(1) : ((window_q > WinCap) ? WinCap : window_q);
  assign in_win = !alu_res.is_neg && (alu_res.diff < {{(SEQ_W - WIN_W){1'b0}}, w_eff});

  assign slot_sum = {1'b0, head_q} + {1'b0, alu_res.diff[IdxW-1:0]};
  assign slot_idx = (slot_sum >= DepthW) ? IdxW'(slot_sum - DepthW) : slot_sum[IdxW-1:0];

  swr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (slot_idx),
    .wdata_i ({in_q.seq, in_q.length, in_q.payload_handle}),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign push_ok        = !pend_valid_q || !out_valid_q || out_ready_i;
  assign drain_done_cum = (policy_q == ACK_CUMULATIVE);

  always_comb begin
    state_d      = state_q;
    in_d         = in_q;
    expected_d   = expected_q;
    head_d       = head_q;
    open_d       = open_q;
    valid_d      = valid_q;
    window_d     = window_q;
    policy_d     = policy_q;
    w_d          = w_q;
    cnt_d        = cnt_q;
    rd_valid_d   = rd_valid_q;
    pend_d       = pend_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    emit_en      = 1'b0;
    finish_en    = 1'b0;
    emit_item    = '{kind: KIND_ACK, seq_res: in_q.seq, length_res: '0,
                     payload_handle_res: '0, last: 1'b0};

    if (cfg_we_i) begin
      if (cfg_idx_i == CFG_WINDOW_SIZE) begin
        window_d = cfg_wdata_i[WIN_W-1:0];
      end else if (cfg_idx_i == CFG_ACK_POLICY) begin
        policy_d = cfg_wdata_i[0];
      end
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        if (!in_q.checksum_ok) begin
          state_d = S_IDLE;
        end else begin
          case (in_q.mode)
            MODE_START: begin
              if (open_q) begin
                state_d = S_IDLE;
              end else if (push_ok) begin
                emit_en    = 1'b1;
                valid_d    = '0;
                expected_d = '0;
                head_d     = '0;
                open_d     = 1'b1;
                state_d    = S_FINISH;
              end
            end
            MODE_DATA: begin
              if (!open_q) begin
                state_d = S_IDLE;
              end else if (policy_q == ACK_CUMULATIVE) begin
                w_d   = w_eff;
                cnt_d = '0;
                if (in_win) begin
                  ram_we            = 1'b1;
                  valid_d[slot_idx] = 1'b1;
                  state_d           = alu_res.is_zero ? S_DRAIN_RD : S_ACK_EXP;
                end else begin
                  state_d = S_ACK_EXP;
                end
              end else if (!alu_res.is_neg && !in_win) begin
                state_d = S_IDLE;
              end else if (push_ok) begin
                emit_en = 1'b1;
                w_d     = w_eff;
                cnt_d   = '0;
                if (!alu_res.is_neg) begin
                  ram_we            = 1'b1;
                  valid_d[slot_idx] = 1'b1;
                  state_d           = alu_res.is_zero ? S_DRAIN_RD : S_FINISH;
                end else begin
                  state_d = S_FINISH;
                end
              end
            end
            MODE_END: begin
              if (!open_q) begin
                state_d = S_IDLE;
              end else if (push_ok) begin
                emit_en = 1'b1;
                open_d  = 1'b0;
                state_d = S_FINISH;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_DRAIN_RD: begin
        if (cnt_q == w_q) begin
          state_d = drain_done_cum ? S_ACK_EXP : S_FINISH;
        end else begin
          ram_re     = 1'b1;
          rd_valid_d = valid_q[head_q];
          state_d    = S_DRAIN_CMP;
        end
      end
      S_DRAIN_CMP: begin
        if (!alu_res.is_zero) begin
          state_d = drain_done_cum ? S_ACK_EXP : S_FINISH;
        end else if (push_ok) begin
          emit_en   = 1'b1;
          emit_item = '{kind: KIND_DELIVER, seq_res: slot_seq,
                        length_res: ram_rdata[LEN_W+HANDLE_W-1 -: LEN_W],
                        payload_handle_res: ram_rdata[HANDLE_W-1:0], last: 1'b0};
          head_d     = (head_q == LastIdx) ? '0 : head_q + IdxW'(1);
          expected_d = expected_q + SEQ_W'(1);
          cnt_d      = cnt_q + WIN_W'(1);
          state_d    = S_DRAIN_RD;
        end
      end
      S_ACK_EXP: begin
        if (push_ok) begin
          emit_en   = 1'b1;
          emit_item = '{kind: KIND_ACK, seq_res: expected_q, length_res: '0,
                        payload_handle_res: '0, last: 1'b0};
          state_d   = S_FINISH;
        end
      end
      S_FINISH: begin
        if (push_ok) begin
          finish_en = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if ((emit_en || finish_en) && pend_valid_q) begin
      out_valid_d = 1'b1;
      out_d       = pend_q;
      out_d.last  = finish_en;
    end
    if (emit_en) begin
      pend_d       = emit_item;
      pend_valid_d = 1'b1;
    end
    if (finish_en) begin
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      expected_q   <= '0;
      head_q       <= '0;
      open_q       <= 1'b0;
      valid_q      <= '0;
      window_q     <= WINDOW_RESET;
      policy_q     <= ACK_CUMULATIVE;
      w_q          <= WIN_W'(1);
      cnt_q        <= '0;
      rd_valid_q   <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      expected_q   <= expected_d;
      head_q       <= head_d;
      open_q       <= open_d;
      valid_q      <= valid_d;
      window_q     <= window_d;
      policy_q     <= policy_d;
      w_q          <= w_d;
      cnt_q        <= cnt_d;
      rd_valid_q   <= rd_valid_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q   <= in_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !pend_valid_q)
    else $error("Pending result left over while waiting for a transaction.");

  a_drain_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= w_q)
    else $error("Delivery count exceeded the window.");

  a_cmp_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DRAIN_CMP |-> $past(state_q) == S_DRAIN_RD || $past(state_q) == S_DRAIN_CMP)
    else $error("Slot compare entered without a slot read.");

  a_head_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(head_q) < BUFFER_DEPTH)
    else $error("Head slot outside the buffer.");

endmodule

FILE: rtl/swr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module swr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/swr_alu.sv
// Shared sequence-number unit: wrapping distance, equality and sign.
`timescale 1ns / 1ps
module swr_alu
  import swr_pkg::*;
(
  input  logic [SEQ_W-1:0] a_i,
  input  logic [SEQ_W-1:0] b_i,
  output swr_alu_res_t     res_o
);

  logic [SEQ_W-1:0] diff;

  assign diff          = a_i - b_i;
  assign res_o.diff    = diff;
  assign res_o.is_zero = (diff == '0);
  assign res_o.is_neg  = diff[SEQ_W-1];

endmodule

FILE: verif/tb_sliding_window_receiver_core.sv
// Self-checking testbench for the sliding-window receiver core.
`timescale 1ns / 1ps
module tb_sliding_window_receiver_core;
  import swr_pkg::*;

  localparam int DEPTH = BUFFER_DEPTH_DEF;
  localparam int WMAX = WINDOW_MAX_DEF;
  localparam logic [MODE_W-1:0] MODE_OTHER = 2'd3;
  localparam int SETTLE_CYCLES = 80;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int ITEMS_TARGET = 370;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  swr_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  swr_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_WINDOW_SIZE;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  sliding_window_receiver_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  logic [SEQ_W-1:0] held_seq [DEPTH];
  logic [LEN_W-1:0] held_len [DEPTH];
  logic [HANDLE_W-1:0] held_handle [DEPTH];
  logic [SEQ_W-1:0] next_seq;
  int unsigned head_idx;
  bit rx_open;
  logic [WIN_W-1:0] cfg_window;
  logic cfg_policy;

  swr_out_t ack_delivery_q[$];
  int error_count = 0;
  int packets_in = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit gaps_on = 1'b1;
  bit stalls_on = 1'b1;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned active_window();
    int unsigned w;
    w = cfg_window;
    if (w < 1) w = 1;
    if (w > WMAX) w = WMAX;
    if (w > DEPTH - 1) w = DEPTH - 1;
    return w;
  endfunction

  function automatic void clear_slots();
    for (int i = 0; i < DEPTH; i++) begin
      held_seq[i] = '0;
      held_len[i] = '0;
      held_handle[i] = '0;
    end
  endfunction

  function automatic void queue_result(input logic kind, input logic [SEQ_W-1:0] seq,
                                       input logic [LEN_W-1:0] len,
                                       input logic [HANDLE_W-1:0] handle);
    swr_out_t res;
    res.kind = kind;
    res.seq_res = seq;
    res.length_res = len;
    res.payload_handle_res = handle;
    res.last = 1'b0;
    ack_delivery_q.push_back(res);
  endfunction

  function automatic int release_in_order(input swr_in_t pkt, input logic [SEQ_W-1:0] offset,
                                          input int unsigned w);
    int unsigned idx;
    int n;
    n = 0;
    idx = (head_idx + offset) % DEPTH;
    held_seq[idx] = pkt.seq;
    held_len[idx] = pkt.length;
    held_handle[idx] = pkt.payload_handle;
    if (offset == '0) begin
      while (n < w && held_seq[head_idx] == next_seq) begin
        queue_result(KIND_DELIVER, held_seq[head_idx], held_len[head_idx],
                     held_handle[head_idx]);
        head_idx = (head_idx + 1) % DEPTH;
        next_seq = next_seq + 1'b1;
        n++;
      end
    end
    return n;
  endfunction

  function automatic int receive_packet(input swr_in_t pkt);
    int unsigned w;
    logic [SEQ_W-1:0] offset;
    int n;
    swr_out_t tail;
    n = 0;
    w = active_window();
    offset = pkt.seq - next_seq;
    if (pkt.checksum_ok) begin
      if (pkt.mode == MODE_START && !rx_open) begin
        queue_result(KIND_ACK, pkt.seq, '0, '0);
        n = 1;
        clear_slots();
        next_seq = '0;
        head_idx = 0;
        rx_open = 1'b1;
      end else if (pkt.mode == MODE_DATA && rx_open) begin
        if (cfg_policy == ACK_CUMULATIVE) begin
          if (!offset[SEQ_W-1] && offset < w) n += release_in_order(pkt, offset, w);
          queue_result(KIND_ACK, next_seq, '0, '0);
          n++;
        end else if (offset[SEQ_W-1] || offset < w) begin
          queue_result(KIND_ACK, pkt.seq, '0, '0);
          n++;
          if (!offset[SEQ_W-1]) n += release_in_order(pkt, offset, w);
        end
      end else if (pkt.mode == MODE_END && rx_open) begin
        queue_result(KIND_ACK, pkt.seq, '0, '0);
        n = 1;
        rx_open = 1'b0;
      end
    end
    if (n > 0) begin
      tail = ack_delivery_q.pop_back();
      tail.last = 1'b1;
      ack_delivery_q.push_back(tail);
    end
    return n;
  endfunction

  function automatic int random_pause();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int idle_gap();
    if (!gaps_on || $urandom_range(0, 99) < 55) return 0;
    return random_pause();
  endfunction

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return 6'd33;
      default: return WIN_W'($urandom_range(2, 12));
    endcase
  endfunction

  task automatic send_packet(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq,
                             input logic [LEN_W-1:0] len, input logic [HANDLE_W-1:0] handle,
                             input logic ok);
    int gap;
    swr_in_t pkt;
    gap = idle_gap();
    pkt.mode = mode;
    pkt.seq = seq;
    pkt.length = len;
    pkt.payload_handle = handle;
    pkt.checksum_ok = ok;
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i <= pkt;
    do @(posedge clk_i); while (!in_ready_o);
    void'(receive_packet(pkt));
    packets_in++;
  endtask

  task automatic send_rand(input logic [MODE_W-1:0] mode, input logic [SEQ_W-1:0] seq);
    send_packet(mode, seq, LEN_W'($urandom), HANDLE_W'($urandom), 1'b1);
  endtask

  task automatic set_config(input logic [WIN_W-1:0] window, input logic policy);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ack_delivery_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_WINDOW_SIZE;
    cfg_wdata_i <= CFG_DATA_W'(window);
    @(negedge clk_i);
    cfg_idx_i <= CFG_ACK_POLICY;
    cfg_wdata_i <= CFG_DATA_W'(policy);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_window = window;
    cfg_policy = policy;
  endtask

  task automatic fill_window();
    int unsigned w;
    int unsigned order[$];
    int unsigned j;
    int unsigned t;
    logic [SEQ_W-1:0] base;
    w = active_window();
    base = next_seq;
    for (int unsigned k = 1; k < w; k++) order.push_back(k);
    for (int i = order.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = order[i];
      order[i] = order[j];
      order[j] = t;
    end
    foreach (order[i]) send_rand(MODE_DATA, base + order[i]);
    send_rand(MODE_DATA, base);
  endtask

  task automatic test_closed_session();
    send_rand(MODE_DATA, 32'd0);
    send_rand(MODE_END, 32'd5);
    send_packet(MODE_START, 32'd0, 16'hFFFF, 16'hFFFF, 1'b0);
    send_rand(MODE_OTHER, 32'd7);
    send_rand(MODE_START, 32'hFFFF_FFFF);
    send_rand(MODE_START, 32'd0);
  endtask

  task automatic test_cumulative_window();
    send_packet(MODE_DATA, 32'd0, 16'hFFFF, 16'h0000, 1'b1);
    send_packet(MODE_DATA, 32'd2, 16'h0000, 16'hFFFF, 1'b1);
    send_rand(MODE_DATA, 32'd3);
    send_rand(MODE_DATA, 32'd1);
    send_rand(MODE_DATA, 32'd0);
    send_rand(MODE_DATA, 32'd11);
    send_rand(MODE_DATA, 32'd12);
    send_rand(MODE_DATA, 32'h8000_0004);
    send_rand(MODE_DATA, 32'h8000_0003);
    send_packet(MODE_DATA, 32'd4, 16'h1234, 16'h5678, 1'b0);
    send_rand(MODE_OTHER, 32'd4);
    send_rand(MODE_END, 32'd0);
  endtask

  task automatic test_selective_window();
    set_config(6'd8, ACK_SELECTIVE);
    send_rand(MODE_START, 32'h1234_5678);
    send_rand(MODE_DATA, 32'd1);
    send_rand(MODE_DATA, 32'd0);
    send_rand(MODE_DATA, 32'd1);
    send_rand(MODE_DATA, 32'd10);
    send_rand(MODE_DATA, 32'd9);
    send_rand(MODE_DATA, 32'd2);
    send_rand(MODE_END, 32'hA5A5_5A5A);
  endtask

  task automatic test_window_extremes();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_config(6'd0, ACK_CUMULATIVE);
    send_rand(MODE_START, 32'd0);
    send_rand(MODE_DATA, 32'd1);
    send_rand(MODE_DATA, 32'd0);
    send_rand(MODE_DATA, 32'd1);
    set_config(6'd63, ACK_SELECTIVE);
    fill_window();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    set_config(6'd33, ACK_CUMULATIVE);
    fill_window();
    set_config(6'd32, ACK_SELECTIVE);
    fill_window();
    send_rand(MODE_END, 32'hFFFF_FFFF);
  endtask

  task automatic send_random_data();
    int unsigned w;
    int r;
    logic [SEQ_W-1:0] seq;
    w = active_window();
    r = $urandom_range(0, 99);
    if (r < 35) seq = next_seq + $urandom_range(0, (w > 4) ? 3 : w - 1);
    else if (r < 60) seq = next_seq + $urandom_range(0, w - 1);
    else if (r < 72) seq = next_seq;
    else if (r < 80) seq = next_seq - $urandom_range(1, 12);
    else if (r < 87) seq = next_seq + w + $urandom_range(0, 4);
    else seq = $urandom();
    if (r < 93) begin
      send_rand(MODE_DATA, seq);
    end else begin
      send_packet(MODE_W'($urandom_range(0, 3)), $urandom(), LEN_W'($urandom),
                  HANDLE_W'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic test_random_sessions();
    int n_data;
    while (packets_in < ITEMS_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) set_config(pick_window(), 1'($urandom_range(0, 1)));
      send_packet(MODE_START, $urandom(), LEN_W'($urandom), HANDLE_W'($urandom),
                  1'($urandom_range(0, 9) != 0));
      n_data = $urandom_range(4, 30);
      repeat (n_data) begin
        if ($urandom_range(0, 39) == 0) set_config(pick_window(), 1'($urandom_range(0, 1)));
        send_random_data();
      end
      if ($urandom_range(0, 9) != 0) send_rand(MODE_END, $urandom());
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 99) < 25) begin
      stall_left = random_pause() - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [SEQ_W-1:0] want,
                             input logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    swr_out_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (ack_delivery_q.size() == 0) begin
        $error("Unexpected transaction: kind %0h seq %0h", out_data_o.kind,
               out_data_o.seq_res);
        error_count++;
      end else begin
        want = ack_delivery_q.pop_front();
        check_field("kind", SEQ_W'(want.kind), SEQ_W'(out_data_o.kind));
        check_field("seq_res", want.seq_res, out_data_o.seq_res);
        check_field("length_res", SEQ_W'(want.length_res), SEQ_W'(out_data_o.length_res));
        check_field("payload_handle_res", SEQ_W'(want.payload_handle_res),
                    SEQ_W'(out_data_o.payload_handle_res));
        check_field("last", SEQ_W'(want.last), SEQ_W'(out_data_o.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $error("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    clear_slots();
    next_seq = '0;
    head_idx = 0;
    rx_open = 1'b0;
    cfg_window = WINDOW_RESET;
    cfg_policy = ACK_CUMULATIVE;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_closed_session();
    test_cumulative_window();
    test_selective_window();
    test_window_extremes();
    test_random_sessions();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (ack_delivery_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
